// File: rtl/fra_pkg.sv
`timescale 1ns / 1ps

package fra_pkg;

    localparam int unsigned IDX_W   = 11;
    localparam int unsigned DELTA_W = 32;
    localparam int unsigned SUM_W   = 64;
    localparam int unsigned S_DATA_W = 56;  // first, last, delta, padded to bytes
    localparam int unsigned M_DATA_W = 64;

    localparam logic [IDX_W-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [0:0] {
        ACT_ADD   = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_NEXT,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_PRE_RD,
        ST_PRE_ACC,
        ST_DONE
    } t_state;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
    } t_alu_req;

endpackage

// File: rtl/fra_mem.sv
`timescale 1ns / 1ps

module fra_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [fra_pkg::SUM_W-1:0]    i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [fra_pkg::SUM_W-1:0]    o_rd_data
);

    logic [fra_pkg::SUM_W-1:0] r_mem [DEPTH];
    logic [fra_pkg::SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/fra_alu.sv
`timescale 1ns / 1ps

module fra_alu (
    input  fra_pkg::t_alu_req            i_req,
    output logic [fra_pkg::SUM_W-1:0]    o_result
);

    always_comb begin
        case (i_req.op)
            fra_pkg::ALU_ADD: o_result = i_req.a + i_req.b;
            fra_pkg::ALU_SUB: o_result = i_req.a - i_req.b;
            default:          o_result = i_req.a + i_req.b;
        endcase
    end

endmodule

// File: rtl/fra_ctrl.sv
`timescale 1ns / 1ps

module fra_ctrl #(
    parameter int unsigned CAPACITY = 1024,
    parameter int unsigned AW       = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [fra_pkg::IDX_W-1:0]       i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fra_pkg::t_action                i_action,
    input  logic [fra_pkg::IDX_W-1:0]       i_first,
    input  logic [fra_pkg::IDX_W-1:0]       i_last,
    input  logic [fra_pkg::DELTA_W-1:0]     i_delta,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fra_pkg::SUM_W-1:0]       o_out_data,
    output logic                            o_mem_wr_en,
    output logic [AW-1:0]                   o_mem_wr_addr,
    output logic [fra_pkg::SUM_W-1:0]       o_mem_wr_data,
    output logic                            o_mem_rd_en,
    output logic [AW-1:0]                   o_mem_rd_addr,
    input  logic [fra_pkg::SUM_W-1:0]       i_mem_rd_data,
    output fra_pkg::t_alu_req               o_alu_req,
    input  logic [fra_pkg::SUM_W-1:0]       i_alu_result
);

    localparam int unsigned PW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = ((PW > fra_pkg::IDX_W) ? PW : fra_pkg::IDX_W) + 1;
    localparam int unsigned SW = fra_pkg::SUM_W;

    fra_pkg::t_state r_state, n_state;

    logic [fra_pkg::IDX_W-1:0] r_count;
    logic [XW-1:0]             r_first, n_first;
    logic [XW-1:0]             r_lim, n_lim;
    logic [XW-1:0]             r_j, n_j;
    logic [XW-1:0]             r_hi, n_hi;
    logic [XW-1:0]             r_pos, n_pos;
    logic [SW-1:0]             r_delta, n_delta;
    logic [SW-1:0]             r_acc, n_acc;
    logic [SW-1:0]             r_hi_sum, n_hi_sum;
    logic                      r_phase, n_phase;
    logic [AW-1:0]             r_clr_addr, n_clr_addr;
    logic                      r_out_valid, n_out_valid;
    logic [SW-1:0]             r_out_data, n_out_data;

    logic [XW-1:0] w_count_x;
    logic [XW-1:0] w_lim;
    logic [XW-1:0] w_in_first;
    logic [XW-1:0] w_in_last;
    logic [XW-1:0] w_lo;
    logic [XW-1:0] w_pos_m1;
    logic [XW-1:0] w_low;
    logic [XW-1:0] w_first_m1;
    logic          w_out_free;

    assign w_count_x  = XW'(r_count);
    assign w_lim      = (w_count_x > XW'(CAPACITY)) ? XW'(CAPACITY) : w_count_x;
    assign w_in_first = XW'(i_first);
    assign w_in_last  = XW'(i_last);
    assign w_lo       = (w_in_first == '0) ? XW'(1) : w_in_first;
    assign w_pos_m1   = r_pos - XW'(1);
    assign w_low      = r_pos & (~r_pos + XW'(1));
    assign w_first_m1 = (r_first == '0) ? '0 : (r_first - XW'(1));
    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and register updates
    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_lim       = r_lim;
        n_j         = r_j;
        n_hi        = r_hi;
        n_pos       = r_pos;
        n_delta     = r_delta;
        n_acc       = r_acc;
        n_hi_sum    = r_hi_sum;
        n_phase     = r_phase;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        case (r_state)
            fra_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(CAPACITY - 1)) begin
                    n_state = fra_pkg::ST_IDLE;
                end
            end
            fra_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_first = w_in_first;
                    n_lim   = w_lim;
                    n_delta = {{(SW - fra_pkg::DELTA_W){i_delta[fra_pkg::DELTA_W-1]}}, i_delta};
                    if (i_action == fra_pkg::ACT_ADD) begin
                        n_j     = w_lo;
                        n_hi    = (w_in_last > w_lim) ? w_lim : w_in_last;
                        n_state = fra_pkg::ST_ADD_NEXT;
                    end else begin
                        n_pos   = (w_in_last > w_lim) ? w_lim : w_in_last;
                        n_acc   = '0;
                        n_phase = 1'b0;
                        n_state = fra_pkg::ST_PRE_RD;
                    end
                end
            end
            fra_pkg::ST_ADD_NEXT: begin
                if (r_j > r_hi) begin
                    n_state = fra_pkg::ST_IDLE;
                end else begin
                    n_pos   = r_j;
                    n_state = fra_pkg::ST_UPD_RD;
                end
            end
            fra_pkg::ST_UPD_RD: begin
                if (r_pos > r_lim) begin
                    n_j     = r_j + XW'(1);
                    n_state = fra_pkg::ST_ADD_NEXT;
                end else begin
                    n_state = fra_pkg::ST_UPD_WR;
                end
            end
            fra_pkg::ST_UPD_WR: begin
                // climb to the parent node
                n_pos   = r_pos + w_low;
                n_state = fra_pkg::ST_UPD_RD;
            end
            fra_pkg::ST_PRE_RD: begin
                if (r_pos == '0) begin
                    if (!r_phase) begin
                        n_hi_sum = r_acc;
                        n_acc    = '0;
                        n_phase  = 1'b1;
                        n_pos    = (w_first_m1 > r_lim) ? r_lim : w_first_m1;
                    end else begin
                        n_state = fra_pkg::ST_DONE;
                    end
                end else begin
                    n_state = fra_pkg::ST_PRE_ACC;
                end
            end
            fra_pkg::ST_PRE_ACC: begin
                n_acc   = i_alu_result;
                n_pos   = r_pos - w_low;
                n_state = fra_pkg::ST_PRE_RD;
            end
            fra_pkg::ST_DONE: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = i_alu_result;
                    n_state     = fra_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fra_pkg::ST_IDLE;
            end
        endcase
    end

    // memory port and shared adder control
    always_comb begin
        o_in_ready    = 1'b0;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = w_pos_m1[AW-1:0];
        o_mem_wr_data = i_alu_result;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = w_pos_m1[AW-1:0];
        o_alu_req.op  = fra_pkg::ALU_ADD;
        o_alu_req.a   = r_acc;
        o_alu_req.b   = i_mem_rd_data;
        case (r_state)
            fra_pkg::ST_CLEAR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_clr_addr;
                o_mem_wr_data = '0;
            end
            fra_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            fra_pkg::ST_UPD_RD: begin
                o_mem_rd_en = (r_pos <= r_lim);
            end
            fra_pkg::ST_UPD_WR: begin
                o_mem_wr_en = 1'b1;
                o_alu_req.a = i_mem_rd_data;
                o_alu_req.b = r_delta;
            end
            fra_pkg::ST_PRE_RD: begin
                o_mem_rd_en = (r_pos != '0);
            end
            fra_pkg::ST_DONE: begin
                o_alu_req.op = fra_pkg::ALU_SUB;
                o_alu_req.a  = r_hi_sum;
                o_alu_req.b  = r_acc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fra_pkg::ST_CLEAR;
            r_count     <= fra_pkg::COUNT_RESET;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first    <= n_first;
        r_lim      <= n_lim;
        r_j        <= n_j;
        r_hi       <= n_hi;
        r_pos      <= n_pos;
        r_delta    <= n_delta;
        r_acc      <= n_acc;
        r_hi_sum   <= n_hi_sum;
        r_phase    <= n_phase;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/fenwick_range_add_range_sum.sv
// Query: walks the prefix from last_index down to zero, then the prefix from
//   first_index-1, and returns the difference of the two as one result beat.
// Add: for each element from first to last, reads and writes every node on its
//   climb to the root; no result. The partial-sum memory sees one access per step.
// One item at a time; s_axis_tready is high only between items.
// Synchronous active-low reset; a clearing pass over all CAPACITY entries follows.
`timescale 1ns / 1ps

module fenwick_range_add_range_sum #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [fra_pkg::IDX_W-1:0]         i_cfg_wr_data,    // element_count
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // first_index[10:0], last_index[21:11], delta[53:22], zero pad[55:54]
    input  logic [fra_pkg::S_DATA_W-1:0]      i_s_axis_tdata,
    input  logic [0:0]                        i_s_axis_tuser,   // action[0]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [fra_pkg::M_DATA_W-1:0]      o_m_axis_tdata    // range_sum[63:0]
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                          w_mem_wr_en;
    logic [AW-1:0]                 w_mem_wr_addr;
    logic [fra_pkg::SUM_W-1:0]     w_mem_wr_data;
    logic                          w_mem_rd_en;
    logic [AW-1:0]                 w_mem_rd_addr;
    logic [fra_pkg::SUM_W-1:0]     w_mem_rd_data;
    fra_pkg::t_alu_req             w_alu_req;
    logic [fra_pkg::SUM_W-1:0]     w_alu_result;
    fra_pkg::t_action              w_action;

    assign w_action = fra_pkg::t_action'(i_s_axis_tuser[0]);

    fra_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_action      (w_action),
        .i_first       (i_s_axis_tdata[10:0]),
        .i_last        (i_s_axis_tdata[21:11]),
        .i_delta       (i_s_axis_tdata[53:22]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata),
        .o_mem_wr_en   (w_mem_wr_en),
        .o_mem_wr_addr (w_mem_wr_addr),
        .o_mem_wr_data (w_mem_wr_data),
        .o_mem_rd_en   (w_mem_rd_en),
        .o_mem_rd_addr (w_mem_rd_addr),
        .i_mem_rd_data (w_mem_rd_data),
        .o_alu_req     (w_alu_req),
        .i_alu_result  (w_alu_result)
    );

    fra_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr_en),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data),
        .i_rd_en   (w_mem_rd_en),
        .i_rd_addr (w_mem_rd_addr),
        .o_rd_data (w_mem_rd_data)
    );

    fra_alu u_alu (
        .i_req    (w_alu_req),
        .o_result (w_alu_result)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CAPACITY    = 1024;
    localparam int unsigned QUERY_DRAIN = 4 * $clog2(CAPACITY + 1) + 8;
    localparam int unsigned LONG_STALL  = 400;
    localparam int unsigned TAIL_CYCLES = 200;

    typedef logic [fra_pkg::IDX_W-1:0]   t_idx;
    typedef logic [fra_pkg::DELTA_W-1:0] t_delta;
    typedef logic [fra_pkg::SUM_W-1:0]   t_sum;

    typedef struct packed {
        fra_pkg::t_action action;
        t_idx             first_idx;
        t_idx             last_idx;
        t_delta           delta;
    } t_range_op;

    logic                         i_clk;
    logic                         i_rst_n         = 1'b0;
    logic                         i_cfg_wr_en     = 1'b0;
    logic [fra_pkg::IDX_W-1:0]    i_cfg_wr_data   = '0;
    logic                         i_s_axis_tvalid = 1'b0;
    logic                         o_s_axis_tready;
    logic [fra_pkg::S_DATA_W-1:0] i_s_axis_tdata  = '0;
    logic [0:0]                   i_s_axis_tuser  = '0;
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready = 1'b0;
    logic [fra_pkg::M_DATA_W-1:0] o_m_axis_tdata;

    fenwick_range_add_range_sum #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---- tree mirror ----
    t_sum        tree_sums [1:CAPACITY];
    int unsigned count_reg;
    t_sum        sum_expected[$];
    t_range_op   op_backlog[$];
    int unsigned fault_count = 0;

    function automatic int unsigned live_count();
        return (count_reg > CAPACITY) ? CAPACITY : count_reg;
    endfunction

    function automatic void tree_add(int unsigned pos, t_sum amount);
        int unsigned p;
        p = pos;
        if (p == 0) return;
        while (p <= live_count()) begin
            tree_sums[p] += amount;
            p += p & (~p + 1);
        end
    endfunction

    function automatic t_sum tree_prefix(int unsigned pos);
        int unsigned p;
        t_sum        acc;
        p   = (pos > live_count()) ? live_count() : pos;
        acc = '0;
        while (p != 0) begin
            acc += tree_sums[p];
            p -= p & (~p + 1);
        end
        return acc;
    endfunction

    function automatic void fenwick_apply(t_range_op op);
        int unsigned lo;
        int unsigned hi;
        t_sum        amount;
        if (op.action == fra_pkg::ACT_ADD) begin
            amount = {{(fra_pkg::SUM_W - fra_pkg::DELTA_W){op.delta[fra_pkg::DELTA_W-1]}},
                      op.delta};
            lo = (op.first_idx == 0) ? 1 : op.first_idx;
            hi = (op.last_idx > live_count()) ? live_count() : op.last_idx;
            for (int unsigned j = lo; j <= hi; j++)
                tree_add(j, amount);
        end else begin
            sum_expected.push_back(tree_prefix(op.last_idx)
                - tree_prefix((op.first_idx == 0) ? 0 : op.first_idx - 1));
        end
    endfunction

    // ---- stimulus helpers ----
    function automatic t_delta pick_delta();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70) return $urandom;
        if (r < 85) return t_delta'($urandom_range(20, 0)) - t_delta'(10);
        case ($urandom_range(3, 0))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic t_range_op random_op();
        t_range_op   op;
        int unsigned lim;
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        lim       = live_count();
        r         = $urandom_range(99, 0);
        op.action = fra_pkg::t_action'($urandom_range(1, 0));
        op.delta  = pick_delta();
        if (r < 82) begin
            // short ranges starting inside the live elements, a few reversed
            lo = $urandom_range((lim == 0) ? 1 : lim, 1);
            hi = lo + $urandom_range(20, 0);
            op.first_idx = t_idx'((r < 8) ? hi : lo);
            op.last_idx  = t_idx'((r < 8) ? lo : hi);
        end else if (r < 97) begin
            op.first_idx = t_idx'($urandom);
            if (op.action == fra_pkg::ACT_QUERY)
                op.last_idx = t_idx'($urandom);
            else
                op.last_idx = op.first_idx + t_idx'($urandom_range(8, 0));
        end else begin
            // near-full span: slow on adds, so keep these rare
            op.first_idx = t_idx'($urandom_range(3, 0));
            op.last_idx  = t_idx'($urandom_range(2047, (lim > 3) ? lim - 3 : 0));
        end
        return op;
    endfunction

    task automatic push_op(fra_pkg::t_action act, int unsigned first, int unsigned last,
                           t_delta d);
        t_range_op op;
        op.action    = act;
        op.first_idx = t_idx'(first);
        op.last_idx  = t_idx'(last);
        op.delta     = d;
        op_backlog.push_back(op);
    endtask

    task automatic push_random(int unsigned n);
        repeat (n) op_backlog.push_back(random_op());
    endtask

    // Close a phase with a query: once its sum is back the block holds no add either.
    task automatic close_phase();
        push_op(fra_pkg::ACT_QUERY, 1, 2047, $urandom);
        while (op_backlog.size() != 0 || i_s_axis_tvalid || sum_expected.size() != 0)
            @(posedge i_clk);
        repeat (QUERY_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= t_idx'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        count_reg   = value & 32'h7FF;
    endtask

    // ---- source side ----
    t_range_op   op_on_bus;
    int unsigned feed_gap   = 0;
    bit          feed_burst = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            feed_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                fenwick_apply(op_on_bus);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (feed_gap != 0 || op_backlog.size() == 0) begin
                    if (feed_gap != 0) feed_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    op_on_bus = op_backlog.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {2'b00, op_on_bus.delta,
                                        op_on_bus.last_idx, op_on_bus.first_idx};
                    i_s_axis_tuser  <= op_on_bus.action;
                    feed_gap = feed_burst ? 0 : $urandom_range(8, 0);
                    if ($urandom_range(40, 0) == 0) feed_burst = !feed_burst;
                end
            end
        end
    end

    // ---- sink side ----
    logic        stall_req  = 1'b0;
    int unsigned stall_left = 0;
    int unsigned sink_wait  = 0;
    bit          sink_burst = 1'b0;

    always @(posedge i_clk) begin
        if (stall_req)
            stall_left <= LONG_STALL;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (sum_expected.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("range sum %h with no query outstanding", o_m_axis_tdata);
                end else if (o_m_axis_tdata !== sum_expected[0]) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("range_sum mismatch: expected %h, got %h",
                                 sum_expected[0], o_m_axis_tdata);
                    void'(sum_expected.pop_front());
                end else begin
                    void'(sum_expected.pop_front());
                end
                sink_wait = sink_burst ? 0 : $urandom_range(8, 0);
                if ($urandom_range(30, 0) == 0) sink_burst = !sink_burst;
            end else if (o_m_axis_tvalid && sink_wait != 0) begin
                sink_wait--;
            end
            i_m_axis_tready <= (sink_wait == 0) && (stall_left == 0);
        end
    end

    // ---- sequence ----
    initial begin
        for (int unsigned k = 1; k <= CAPACITY; k++) tree_sums[k] = '0;
        count_reg = fra_pkg::COUNT_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, extremes of delta and index, reversed ranges
        push_op(fra_pkg::ACT_QUERY, 1, 1024, 0);
        push_op(fra_pkg::ACT_ADD, 1, 1, 32'h7FFF_FFFF);
        push_op(fra_pkg::ACT_ADD, 1024, 1024, 32'h8000_0000);
        push_op(fra_pkg::ACT_ADD, 0, 2047, 32'hFFFF_FFFF);
        push_op(fra_pkg::ACT_ADD, 5, 3, 7);
        push_op(fra_pkg::ACT_QUERY, 0, 2047, 32'hFFFF_FFFF);
        push_op(fra_pkg::ACT_QUERY, 1, 1, 0);
        push_op(fra_pkg::ACT_QUERY, 1024, 1024, 0);
        push_op(fra_pkg::ACT_QUERY, 7, 3, 0);
        push_op(fra_pkg::ACT_QUERY, 0, 0, 0);
        push_op(fra_pkg::ACT_ADD, 2047, 2047, 1);
        push_op(fra_pkg::ACT_QUERY, 2047, 2047, 0);
        push_op(fra_pkg::ACT_ADD, 512, 700, 32'h1234_5678);
        push_op(fra_pkg::ACT_QUERY, 600, 1024, 0);
        push_op(fra_pkg::ACT_QUERY, 1, 511, 0);
        push_op(fra_pkg::ACT_ADD, 1, 1024, 32'h8000_0000);
        push_op(fra_pkg::ACT_QUERY, 1, 1024, 0);
        push_op(fra_pkg::ACT_QUERY, 2000, 1, 0);
        close_phase();

        // zero elements: adds change nothing, every prefix is zero
        write_count(0);
        push_op(fra_pkg::ACT_ADD, 1, 10, 5);
        push_op(fra_pkg::ACT_QUERY, 1, 10, 0);
        push_op(fra_pkg::ACT_QUERY, 0, 2047, 0);
        push_random(20);
        close_phase();

        // count above capacity saturates
        write_count(2047);
        push_random(120);
        close_phase();

        // shrink over a populated tree, no repair
        write_count(17);
        push_op(fra_pkg::ACT_QUERY, 1, 1024, 0);
        push_random(100);
        close_phase();

        write_count(1);
        push_random(60);
        close_phase();

        write_count(2);
        push_random(40);
        close_phase();

        // hold the sink off while the source keeps offering
        write_count(1024);
        push_op(fra_pkg::ACT_QUERY, 3, 900, 0);
        push_op(fra_pkg::ACT_QUERY, 1, 2, 0);
        push_random(180);
        @(posedge i_clk);
        stall_req <= 1'b1;
        @(posedge i_clk);
        stall_req <= 1'b0;
        close_phase();

        write_count(513);
        push_random(100);
        close_phase();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && sum_expected.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
